/* design/assert_macros.svh */
// Assertion helpers. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/ttg_pkg.sv */
package ttg_pkg;

	localparam int IDX_IN_W  = 16;
	localparam int POS_IN_W  = 24;
	localparam int UV_W      = 16;
	localparam int TAN_W     = 16;
	localparam int WIDE_W    = 32;
	localparam int L2_W      = 62;
	localparam int ROOT_W    = 31;
	localparam int QUO_W     = 15;
	localparam int FRAC_W    = 14;
	localparam int NUM_W     = ROOT_W + FRAC_W;
	localparam int NORM_LO   = 29;
	localparam int NORM_HI   = 30;
	localparam int ONE_Q14   = 16384;

	typedef struct packed {
		logic        [IDX_IN_W-1:0] vertex_index;
		logic signed [POS_IN_W-1:0] pos_x;
		logic signed [POS_IN_W-1:0] pos_y;
		logic signed [POS_IN_W-1:0] pos_z;
		logic signed [UV_W-1:0]     tex_u;
		logic signed [UV_W-1:0]     tex_v;
	} in_item_t;

	typedef struct packed {
		logic        [IDX_IN_W-1:0] target_vertex;
		logic signed [TAN_W-1:0]    tan_x;
		logic signed [TAN_W-1:0]    tan_y;
		logic signed [TAN_W-1:0]    tan_z;
		logic                       right_handed;
		logic                       degenerate;
		logic                       last_of_triangle;
	} out_item_t;

	// Commands to the root / divide unit.
	typedef struct packed {
		logic start_sqrt;
		logic start_div;
	} rd_cmd_t;

endpackage

/* design/ttg_rootdiv.sv */
`include "assert_macros.svh"

// Bit-serial integer square root (one result bit per pass, 31 passes)
// and restoring divide producing a 15 bit quotient (15 passes).
module ttg_rootdiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ttg_pkg::rd_cmd_t              cmd,
	input  logic [ttg_pkg::L2_W-1:0]      radicand,
	input  logic [ttg_pkg::NUM_W-1:0]     dividend,
	input  logic [ttg_pkg::ROOT_W-1:0]    divisor,
	output logic                          done,
	output logic [ttg_pkg::ROOT_W-1:0]    result
);

	typedef enum logic [1:0] {RD_IDLE, RD_SQRT, RD_DIV} rd_state_t;

	rd_state_t                      state_q;
	logic [ttg_pkg::L2_W-1:0]       x_q;
	logic [ttg_pkg::L2_W-1:0]       res_q;
	logic [ttg_pkg::L2_W-2:0]       bit_q;
	logic [ttg_pkg::NUM_W-1:0]      rem_q;
	logic [ttg_pkg::NUM_W-1:0]      dsh_q;
	logic [ttg_pkg::QUO_W-1:0]      quo_q;
	logic [3:0]                     cnt_q;
	logic                           done_q;
	logic                           was_div_q;
	logic [ttg_pkg::L2_W-1:0]       trial;

	assign trial  = res_q + {1'b0, bit_q};
	assign done   = done_q;
	assign result = was_div_q ? ttg_pkg::ROOT_W'(quo_q) : res_q[ttg_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= RD_IDLE;
			x_q       <= '0;
			res_q     <= '0;
			bit_q     <= '0;
			rem_q     <= '0;
			dsh_q     <= '0;
			quo_q     <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			was_div_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				RD_IDLE: begin
					if (cmd.start_sqrt) begin
						x_q       <= radicand;
						res_q     <= '0;
						bit_q     <= {1'b1, {(ttg_pkg::L2_W-2){1'b0}}};
						was_div_q <= 1'b0;
						state_q   <= RD_SQRT;
					end else if (cmd.start_div) begin
						rem_q     <= dividend;
						dsh_q     <= {divisor, {ttg_pkg::FRAC_W{1'b0}}};
						quo_q     <= '0;
						cnt_q     <= 4'(ttg_pkg::QUO_W - 1);
						was_div_q <= 1'b1;
						state_q   <= RD_DIV;
					end
				end
				RD_SQRT: begin
					if (x_q >= trial) begin
						x_q   <= x_q - trial;
						res_q <= (res_q >> 1) + {1'b0, bit_q};
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						done_q  <= 1'b1;
						state_q <= RD_IDLE;
					end
				end
				RD_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[ttg_pkg::QUO_W-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[ttg_pkg::QUO_W-2:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						done_q  <= 1'b1;
						state_q <= RD_IDLE;
					end
				end
				default: state_q <= RD_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_cmd_excl, cmd.start_sqrt, !cmd.start_div)
	`ASSERT_NEXT(a_done_idle, done_q, state_q == RD_IDLE || cmd.start_sqrt || cmd.start_div)
	`ASSERT_IMPLIES(a_sqrt_bit, state_q == RD_SQRT, $onehot(bit_q))

endmodule

/* design/triangle_tangent_generator.sv */
// Triangle tangent generator: one unit tangent per three corners.
// Corners a and b are only stored, with no result. Corner c starts the work
// (14 products on one shared multiplier, a one bit per cycle normalizing shift,
// 3 squares, a 31 pass root, 3 x 15 divide passes), then three results leave one
// per cycle through an output register while out_ready does not stall it.
// Reset (arst_n low, async) clears the corner count, the sequencer and out_valid.
`include "assert_macros.svh"

module triangle_tangent_generator #(
	parameter int INDEX_BITS = 16,
	parameter int POS_BITS   = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ttg_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ttg_pkg::out_item_t  out_item
);

	// Datapath widths follow from the position width.
	localparam int DW   = POS_BITS + 1;              // position difference
	localparam int MW   = (DW > 31) ? DW : 31;       // multiplier operand
	localparam int PRW  = 2 * MW;                    // product
	localparam int UVD  = ttg_pkg::UV_W + 1;         // uv difference
	localparam int DETW = 2 * UVD + 1;               // determinant
	localparam int TW   = DW + UVD + 1;              // unnormalized tangent
	localparam int MAGW = (TW > 31) ? TW : 31;       // tangent magnitude
	localparam int NPROD = 14;                       // det, T and cross products

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_CHK, ST_NORM, ST_SQ, ST_ROOT, ST_DIV, ST_EMIT
	} state_t;

	state_t                         state_q;
	logic [1:0]                     cnt_q;      // corners held
	logic [4:0]                     step_q;
	logic [1:0]                     k_q;        // divide component / emit corner

	// held corners a and b
	logic signed [POS_BITS-1:0]     pa_q [3];
	logic signed [POS_BITS-1:0]     pb_q [3];
	logic signed [ttg_pkg::UV_W-1:0] ta_q [2];
	logic signed [ttg_pkg::UV_W-1:0] tb_q [2];
	logic [INDEX_BITS-1:0]          idx_q [3];

	// edge and uv deltas
	logic signed [DW-1:0]           ba_q [3];
	logic signed [DW-1:0]           ca_q [3];
	logic signed [UVD-1:0]          du1_q, dv1_q, du2_q, dv2_q;

	// shared multiplier
	logic signed [MW-1:0]           op_a, op_b;
	logic signed [PRW-1:0]          prod_q;
	logic signed [PRW-1:0]          first_q;
	logic signed [PRW-1:0]          diff;

	logic signed [DETW-1:0]         det_q;
	logic signed [TW-1:0]           t_q [3];
	logic                           nz_q;
	logic                           rh_q, degen_q;
	logic [MAGW-1:0]                m_q [3];
	logic [MAGW-1:0]                mx;
	logic [ttg_pkg::L2_W-1:0]       l2_q;
	logic [ttg_pkg::ROOT_W-1:0]     r_q;
	logic signed [ttg_pkg::TAN_W-1:0] q_q [3];

	// root / divide unit
	ttg_pkg::rd_cmd_t               cmd_q;
	logic [ttg_pkg::NUM_W-1:0]      num;
	logic                           rd_done;
	logic [ttg_pkg::ROOT_W-1:0]     rd_result;
	logic [ttg_pkg::QUO_W-1:0]      quo;
	logic [ttg_pkg::TAN_W-1:0]      sat;

	logic                           out_valid_q;
	ttg_pkg::out_item_t             out_q;
	logic                           in_fire;
	logic                           out_free;

	logic signed [POS_BITS-1:0]     pc [3];
	logic [INDEX_BITS-1:0]          idx_in;

	// Fields are truncated to their low POS_BITS bits and indices masked to INDEX_BITS.
	function automatic logic signed [POS_BITS-1:0] pos_take(input logic [ttg_pkg::POS_IN_W-1:0] f);
		logic [ttg_pkg::WIDE_W-1:0] z;
		z = {{(ttg_pkg::WIDE_W - ttg_pkg::POS_IN_W){1'b0}}, f};
		return z[POS_BITS-1:0];
	endfunction

	function automatic logic signed [MW-1:0] mag_op(input logic [MAGW-1:0] m);
		return MW'($signed({1'b0, m[NORM_HI_IDX-1:0]}));
	endfunction
	localparam int NORM_HI_IDX = ttg_pkg::NORM_HI;

	function automatic logic [MAGW-1:0] abs_t(input logic signed [TW-1:0] t);
		logic [TW-1:0] u;
		u = t[TW-1] ? TW'(-t) : TW'(t);
		return MAGW'(u);
	endfunction

	assign in_fire  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign pc[0] = pos_take(in_item.pos_x);
	assign pc[1] = pos_take(in_item.pos_y);
	assign pc[2] = pos_take(in_item.pos_z);
	assign idx_in = INDEX_BITS'({{(ttg_pkg::WIDE_W - ttg_pkg::IDX_IN_W){1'b0}},
		in_item.vertex_index});

	assign diff = first_q - prod_q;

	// Largest magnitude drives the normalizing shift.
	always_comb begin
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
	end

	// Operand select for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_MUL) begin
			case (step_q)
				5'd0:  begin op_a = MW'(du1_q);   op_b = MW'(dv2_q);   end
				5'd1:  begin op_a = MW'(du2_q);   op_b = MW'(dv1_q);   end
				5'd2:  begin op_a = MW'(ba_q[0]); op_b = MW'(dv2_q);   end
				5'd3:  begin op_a = MW'(ca_q[0]); op_b = MW'(dv1_q);   end
				5'd4:  begin op_a = MW'(ba_q[1]); op_b = MW'(dv2_q);   end
				5'd5:  begin op_a = MW'(ca_q[1]); op_b = MW'(dv1_q);   end
				5'd6:  begin op_a = MW'(ba_q[2]); op_b = MW'(dv2_q);   end
				5'd7:  begin op_a = MW'(ca_q[2]); op_b = MW'(dv1_q);   end
				5'd8:  begin op_a = MW'(ba_q[1]); op_b = MW'(ca_q[2]); end
				5'd9:  begin op_a = MW'(ba_q[2]); op_b = MW'(ca_q[1]); end
				5'd10: begin op_a = MW'(ba_q[2]); op_b = MW'(ca_q[0]); end
				5'd11: begin op_a = MW'(ba_q[0]); op_b = MW'(ca_q[2]); end
				5'd12: begin op_a = MW'(ba_q[0]); op_b = MW'(ca_q[1]); end
				5'd13: begin op_a = MW'(ba_q[1]); op_b = MW'(ca_q[0]); end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end else if (state_q == ST_SQ && step_q < 5'd3) begin
			op_a = mag_op(m_q[step_q[1:0]]);
			op_b = mag_op(m_q[step_q[1:0]]);
		end
	end

	// Rounded quotient dividend: m * 2^14 + floor(r / 2).
	assign num = {m_q[k_q][NORM_HI_IDX-1:0], {ttg_pkg::FRAC_W{1'b0}}}
		+ ttg_pkg::NUM_W'(r_q >> 1);
	assign quo = rd_result[ttg_pkg::QUO_W-1:0];
	assign sat = (quo > ttg_pkg::QUO_W'(ttg_pkg::ONE_Q14)) ?
		ttg_pkg::TAN_W'(ttg_pkg::ONE_Q14) : ttg_pkg::TAN_W'(quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else begin
			prod_q <= op_a * op_b;
		end
	end

	ttg_rootdiv u_rootdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_q),
		.radicand (l2_q),
		.dividend (num),
		.divisor  (r_q),
		.done     (rd_done),
		.result   (rd_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			k_q         <= '0;
			cmd_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			nz_q        <= 1'b0;
			rh_q        <= 1'b0;
			degen_q     <= 1'b0;
			first_q     <= '0;
			det_q       <= '0;
			l2_q        <= '0;
			r_q         <= '0;
			for (int i = 0; i < 3; i++) begin
				pa_q[i]  <= '0;
				pb_q[i]  <= '0;
				ba_q[i]  <= '0;
				ca_q[i]  <= '0;
				t_q[i]   <= '0;
				m_q[i]   <= '0;
				q_q[i]   <= '0;
				idx_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				ta_q[i] <= '0;
				tb_q[i] <= '0;
			end
			du1_q <= '0; dv1_q <= '0; du2_q <= '0; dv2_q <= '0;
		end else begin
			cmd_q <= '0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (cnt_q == 2'd0) begin
							for (int i = 0; i < 3; i++) pa_q[i] <= pc[i];
							ta_q[0]  <= in_item.tex_u;
							ta_q[1]  <= in_item.tex_v;
							idx_q[0] <= idx_in;
							cnt_q    <= 2'd1;
						end else if (cnt_q == 2'd1) begin
							for (int i = 0; i < 3; i++) pb_q[i] <= pc[i];
							tb_q[0]  <= in_item.tex_u;
							tb_q[1]  <= in_item.tex_v;
							idx_q[1] <= idx_in;
							cnt_q    <= 2'd2;
						end else begin
							// third corner: form edges and uv deltas, start the products
							for (int i = 0; i < 3; i++) begin
								ba_q[i] <= DW'(pb_q[i]) - DW'(pa_q[i]);
								ca_q[i] <= DW'(pc[i]) - DW'(pa_q[i]);
							end
							du1_q    <= UVD'(tb_q[0]) - UVD'(ta_q[0]);
							dv1_q    <= UVD'(tb_q[1]) - UVD'(ta_q[1]);
							du2_q    <= UVD'(in_item.tex_u) - UVD'(ta_q[0]);
							dv2_q    <= UVD'(in_item.tex_v) - UVD'(ta_q[1]);
							idx_q[2] <= idx_in;
							cnt_q    <= 2'd0;
							nz_q     <= 1'b0;
							step_q   <= '0;
							state_q  <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					// issue product step, retire product step-1
					if (step_q != 5'd0) begin
						if (!step_q[0]) begin
							case (step_q)
								5'd2:  det_q <= diff[DETW-1:0];
								5'd4:  t_q[0] <= diff[TW-1:0];
								5'd6:  t_q[1] <= diff[TW-1:0];
								5'd8:  t_q[2] <= diff[TW-1:0];
								default: nz_q <= nz_q || (diff != '0);
							endcase
						end else begin
							first_q <= prod_q;
						end
					end
					if (step_q == 5'(NPROD)) begin
						state_q <= ST_CHK;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_CHK: begin
					for (int i = 0; i < 3; i++) m_q[i] <= abs_t(t_q[i]);
					l2_q <= '0;
					if (det_q == '0 || (t_q[0] == '0 && t_q[1] == '0 && t_q[2] == '0)) begin
						degen_q <= 1'b1;
						rh_q    <= 1'b0;
						for (int i = 0; i < 3; i++) q_q[i] <= '0;
						k_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						degen_q <= 1'b0;
						rh_q    <= det_q[DETW-1] && nz_q;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (mx[MAGW-1:NORM_HI_IDX] != '0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (!mx[ttg_pkg::NORM_LO]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						step_q  <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (step_q != 5'd0) l2_q <= l2_q + prod_q[ttg_pkg::L2_W-1:0];
					if (step_q == 5'd3) begin
						cmd_q.start_sqrt <= 1'b1;
						state_q <= ST_ROOT;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_ROOT: begin
					if (rd_done) begin
						r_q <= rd_result;
						k_q <= '0;
						cmd_q.start_div <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rd_done) begin
						q_q[k_q] <= (t_q[k_q][TW-1] != det_q[DETW-1]) ? -$signed(sat) : $signed(sat);
						if (k_q == 2'd2) begin
							k_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							k_q <= k_q + 2'd1;
							cmd_q.start_div <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q            <= 1'b1;
						out_q.target_vertex    <= ttg_pkg::IDX_IN_W'(
							{{(ttg_pkg::WIDE_W - INDEX_BITS){1'b0}}, idx_q[k_q]});
						out_q.tan_x            <= q_q[0];
						out_q.tan_y            <= q_q[1];
						out_q.tan_z            <= q_q[2];
						out_q.right_handed     <= rh_q;
						out_q.degenerate       <= degen_q;
						out_q.last_of_triangle <= (k_q == 2'd2);
						if (k_q == 2'd2) begin
							k_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_q != 2'd3)
	`ASSERT_IMPLIES(a_degen_zero, out_valid_q && out_q.degenerate,
		out_q.tan_x == '0 && out_q.tan_y == '0 && out_q.tan_z == '0 && !out_q.right_handed)
	`ASSERT_IMPLIES(a_tan_range, out_valid_q,
		out_q.tan_x <= 16'sd16384 && out_q.tan_x >= -16'sd16384)
	`ASSERT_IMPLIES(a_step_range, state_q == ST_MUL, step_q <= 5'(NPROD))

endmodule
